[rtl/md5_pkg.sv]
// MD5 package: FSM state type, sine constants, rotation and message index lookup.
// No dependencies; imported by md5_step, md5_block_compression_top and the bench.
package md5_pkg;

  typedef enum logic [2:0] {
    ST_COLLECT,
    ST_PREP,
    ST_RUN,
    ST_ADD,
    ST_EMIT
  } md5_state_t;

  localparam logic [31:0] INIT_A_RST = 32'h67452301;
  localparam logic [31:0] INIT_B_RST = 32'hefcdab89;
  localparam logic [31:0] INIT_C_RST = 32'h98badcfe;
  localparam logic [31:0] INIT_D_RST = 32'h10325476;

  localparam logic [1:0] REG_INIT_A = 2'd0;
  localparam logic [1:0] REG_INIT_B = 2'd1;
  localparam logic [1:0] REG_INIT_C = 2'd2;
  localparam logic [1:0] REG_INIT_D = 2'd3;

  localparam logic [1:0] ROUND_F = 2'd0;
  localparam logic [1:0] ROUND_G = 2'd1;
  localparam logic [1:0] ROUND_H = 2'd2;
  localparam logic [1:0] ROUND_I = 2'd3;

  localparam logic [31:0] MD5_K [64] = '{
    32'hd76aa478, 32'he8c7b756, 32'h242070db, 32'hc1bdceee,
    32'hf57c0faf, 32'h4787c62a, 32'ha8304613, 32'hfd469501,
    32'h698098d8, 32'h8b44f7af, 32'hffff5bb1, 32'h895cd7be,
    32'h6b901122, 32'hfd987193, 32'ha679438e, 32'h49b40821,
    32'hf61e2562, 32'hc040b340, 32'h265e5a51, 32'he9b6c7aa,
    32'hd62f105d, 32'h02441453, 32'hd8a1e681, 32'he7d3fbc8,
    32'h21e1cde6, 32'hc33707d6, 32'hf4d50d87, 32'h455a14ed,
    32'ha9e3e905, 32'hfcefa3f8, 32'h676f02d9, 32'h8d2a4c8a,
    32'hfffa3942, 32'h8771f681, 32'h6d9d6122, 32'hfde5380c,
    32'ha4beea44, 32'h4bdecfa9, 32'hf6bb4b60, 32'hbebfbc70,
    32'h289b7ec6, 32'heaa127fa, 32'hd4ef3085, 32'h04881d05,
    32'hd9d4d039, 32'he6db99e5, 32'h1fa27cf8, 32'hc4ac5665,
    32'hf4292244, 32'h432aff97, 32'hab9423a7, 32'hfc93a039,
    32'h655b59c3, 32'h8f0ccc92, 32'hffeff47d, 32'h85845dd1,
    32'h6fa87e4f, 32'hfe2ce6e0, 32'ha3014314, 32'h4e0811a1,
    32'hf7537e82, 32'hbd3af235, 32'h2ad7d2bb, 32'heb86d391
  };

  // Left-rotate amount for a step.
  function automatic logic [4:0] md5_rot(input logic [5:0] step);
    logic [4:0] s;
    unique case ({step[5:4], step[1:0]})
      4'd0:  s = 5'd7;
      4'd1:  s = 5'd12;
      4'd2:  s = 5'd17;
      4'd3:  s = 5'd22;
      4'd4:  s = 5'd5;
      4'd5:  s = 5'd9;
      4'd6:  s = 5'd14;
      4'd7:  s = 5'd20;
      4'd8:  s = 5'd4;
      4'd9:  s = 5'd11;
      4'd10: s = 5'd16;
      4'd11: s = 5'd23;
      4'd12: s = 5'd6;
      4'd13: s = 5'd10;
      4'd14: s = 5'd15;
      4'd15: s = 5'd21;
    endcase
    return s;
  endfunction

  // Message word used by a step (mod 16 arithmetic only needs the low nibble).
  function automatic logic [3:0] md5_msg_idx(input logic [5:0] step);
    logic [3:0] l;
    logic [3:0] g;
    l = step[3:0];
    unique case (step[5:4])
      ROUND_F: g = l;
      ROUND_G: g = 4'(l * 4'd5 + 4'd1);
      ROUND_H: g = 4'(l * 4'd3 + 4'd5);
      ROUND_I: g = 4'(l * 4'd7);
    endcase
    return g;
  endfunction

endpackage

[rtl/md5_in_if.sv]
// Input channel: valid/ready handshake with one message word per transfer.
// No dependencies.
interface md5_in_if;
  logic        valid;
  logic        ready;
  logic [31:0] message_word;
  logic        new_message;

  modport source (output valid, output message_word, output new_message, input ready);
  modport sink   (input valid, input message_word, input new_message, output ready);
endinterface

[rtl/md5_out_if.sv]
// Result channel: valid/ready handshake with one digest word per transfer.
// No dependencies.
interface md5_out_if;
  logic        valid;
  logic        ready;
  logic [31:0] digest_word;
  logic [1:0]  word_index;
  logic        last;

  modport source (output valid, output digest_word, output word_index, output last,
                  input ready);
  modport sink   (input valid, input digest_word, input word_index, input last,
                  output ready);
endinterface

[rtl/md5_step.sv]
// Shared MD5 step unit: round function, add, rotate, add.
// Depends on md5_pkg.
module md5_step (
  input  logic [5:0]  step,
  input  logic [31:0] a,
  input  logic [31:0] b,
  input  logic [31:0] c,
  input  logic [31:0] d,
  input  logic [31:0] km,     // K[step] + M[g(step)], precomputed
  output logic [31:0] new_b
);
  import md5_pkg::*;

  logic [31:0] f;
  logic [31:0] t;
  logic [63:0] rot_w;
  logic [4:0]  s;

  always_comb begin
    unique case (step[5:4])
      ROUND_F: f = d ^ (b & (c ^ d));
      ROUND_G: f = c ^ (d & (b ^ c));
      ROUND_H: f = b ^ c ^ d;
      ROUND_I: f = c ^ (b | ~d);
    endcase
  end

  assign s     = md5_rot(step);
  assign t     = a + f + km;
  assign rot_w = {t, t} << s;
  assign new_b = b + rot_w[63:32];

endmodule

[rtl/md5_block_compression_top.sv]
// MD5 block compression top level: word buffer, step sequencer, chaining value, APB regs.
// Depends on md5_pkg, md5_in_if, md5_out_if and md5_step.
//
// Usage:
//   in_ch transfers one 32-bit message word (little-endian assembled) per cycle while
//   in_ch.ready is high. new_message on a word reloads the chaining value from the
//   init registers and restarts the block at word 0. The transfer of word 15 starts
//   compression: a prep state, 64 steps (one step per cycle through the shared
//   md5_step unit) and the final add. Then four results a, b, c, d appear on out_ch,
//   one per transfer, last set on d.
//   in_ch.ready is low from the word-15 transfer until the last result is taken; a
//   stalled receiver simply holds the current result and the block waits.
//   APB (psel/penable/pwrite, paddr[3:2] selects init_a..init_d) writes the init
//   registers; write only while idle. Reads return the register value.
//   Reset (rst_n low, synchronous): init registers and chaining value go to the
//   standard MD5 IV, word position to 0, no result pending.
module md5_block_compression_top (
  input  logic         clk,
  input  logic         rst_n,
  md5_in_if.sink       in_ch,
  md5_out_if.source    out_ch,
  input  logic         psel,
  input  logic         penable,
  input  logic         pwrite,
  input  logic [3:0]   paddr,
  input  logic [31:0]  pwdata,
  output logic [31:0]  prdata,
  output logic         pready
);
  import md5_pkg::*;

  md5_state_t  state_r, state_nxt;
  logic [3:0]  pos_r, pos_nxt;
  logic [5:0]  step_r, step_nxt;
  logic [1:0]  emit_r, emit_nxt;

  logic [31:0] init_r [4];
  logic [31:0] cv_r   [4];
  logic [31:0] buf_r  [16];     // block buffer, undefined until written
  logic [31:0] a_r, b_r, c_r, d_r;
  logic [31:0] km_r;            // K + M for the step held in step_r

  logic        in_xfer;
  logic        out_xfer;
  logic        cfg_wr;
  logic [3:0]  wr_pos;
  logic [5:0]  km_step;
  logic [31:0] km_nxt;
  logic [31:0] step_b;

  assign pready   = 1'b1;
  assign cfg_wr   = psel && penable && pwrite && pready;
  assign prdata   = init_r[paddr[3:2]];

  assign in_ch.ready = (state_r == ST_COLLECT);
  assign in_xfer     = in_ch.valid && in_ch.ready;
  assign out_xfer    = out_ch.valid && out_ch.ready;

  // new_message restarts the block at position 0
  assign wr_pos = in_ch.new_message ? 4'd0 : pos_r;

  // Prefetch K + M one step ahead; in prep this is step 0
  assign km_step = (state_r == ST_RUN) ? 6'(step_r + 6'd1) : 6'd0;
  assign km_nxt  = MD5_K[km_step] + buf_r[md5_msg_idx(km_step)];

  md5_step u_step (
    .step  (step_r),
    .a     (a_r),
    .b     (b_r),
    .c     (c_r),
    .d     (d_r),
    .km    (km_r),
    .new_b (step_b)
  );

  // Sequencer
  always_comb begin
    state_nxt = state_r;
    pos_nxt   = pos_r;
    step_nxt  = step_r;
    emit_nxt  = emit_r;
    unique case (state_r)
      ST_COLLECT: begin
        if (in_xfer) begin
          if (wr_pos == 4'd15) begin
            pos_nxt   = 4'd0;
            state_nxt = ST_PREP;
          end else begin
            pos_nxt = 4'(wr_pos + 4'd1);
          end
        end
      end
      ST_PREP: begin
        step_nxt  = 6'd0;
        state_nxt = ST_RUN;
      end
      ST_RUN: begin
        step_nxt = 6'(step_r + 6'd1);
        if (step_r == 6'd63) begin
          state_nxt = ST_ADD;
        end
      end
      ST_ADD: begin
        emit_nxt  = 2'd0;
        state_nxt = ST_EMIT;
      end
      ST_EMIT: begin
        if (out_xfer) begin
          emit_nxt = 2'(emit_r + 2'd1);
          if (emit_r == 2'd3) begin
            state_nxt = ST_COLLECT;
          end
        end
      end
      default: state_nxt = ST_COLLECT;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_COLLECT;
      pos_r   <= 4'd0;
      step_r  <= 6'd0;
      emit_r  <= 2'd0;
    end else begin
      state_r <= state_nxt;
      pos_r   <= pos_nxt;
      step_r  <= step_nxt;
      emit_r  <= emit_nxt;
    end
  end

  // Init registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      init_r[REG_INIT_A] <= INIT_A_RST;
      init_r[REG_INIT_B] <= INIT_B_RST;
      init_r[REG_INIT_C] <= INIT_C_RST;
      init_r[REG_INIT_D] <= INIT_D_RST;
    end else if (cfg_wr) begin
      init_r[paddr[3:2]] <= pwdata;
    end
  end

  // Chaining value: reload on new_message, accumulate after the last step
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cv_r[0] <= INIT_A_RST;
      cv_r[1] <= INIT_B_RST;
      cv_r[2] <= INIT_C_RST;
      cv_r[3] <= INIT_D_RST;
    end else if (in_xfer && in_ch.new_message) begin
      cv_r <= init_r;
    end else if (state_r == ST_ADD) begin
      cv_r[0] <= cv_r[0] + a_r;
      cv_r[1] <= cv_r[1] + b_r;
      cv_r[2] <= cv_r[2] + c_r;
      cv_r[3] <= cv_r[3] + d_r;
    end
  end

  // Block buffer
  always_ff @(posedge clk) begin
    if (in_xfer) begin
      buf_r[wr_pos] <= in_ch.message_word;
    end
  end

  // Working registers
  always_ff @(posedge clk) begin
    km_r <= km_nxt;
    if (state_r == ST_PREP) begin
      a_r <= cv_r[0];
      b_r <= cv_r[1];
      c_r <= cv_r[2];
      d_r <= cv_r[3];
    end else if (state_r == ST_RUN) begin
      a_r <= d_r;
      b_r <= step_b;
      c_r <= b_r;
      d_r <= c_r;
    end
  end

  // Results straight from the chaining value registers
  assign out_ch.valid       = (state_r == ST_EMIT);
  assign out_ch.digest_word = cv_r[emit_r];
  assign out_ch.word_index  = emit_r;
  assign out_ch.last        = (emit_r == 2'd3);

endmodule

[rtl/md5_chk.sv]
// Port-level checker for md5_block_compression_top, plus its bind.
// Depends on md5_block_compression_top port names only.
module md5_chk (
  input logic       clk,
  input logic       rst_n,
  input logic       in_valid,
  input logic       in_ready,
  input logic       out_valid,
  input logic       out_ready,
  input logic [1:0] word_index,
  input logic       last
);

  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(word_index))
    else $error("result dropped while stalled");

  a_no_overlap: assert property (@(posedge clk) disable iff (!rst_n)
    !(in_ready && out_valid))
    else $error("input ready while results pending");

  a_last_idx: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (last == (word_index == 2'd3)))
    else $error("last flag mismatch");

  a_seq: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_ready && !last |=>
      out_valid && (word_index == 2'($past(word_index) + 2'd1)))
    else $error("digest words out of order");

  a_end: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_ready && last |=> !out_valid && in_ready)
    else $error("no return to collect after last word");

endmodule

bind md5_block_compression_top md5_chk u_md5_chk (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_valid   (in_ch.valid),
  .in_ready   (in_ch.ready),
  .out_valid  (out_ch.valid),
  .out_ready  (out_ch.ready),
  .word_index (out_ch.word_index),
  .last       (out_ch.last)
);

[bench/md5_block_compression_top_tb.sv]
// Self-checking bench for md5_block_compression_top: directed table plus random blocks,
// every digest transfer compared against an in-bench MD5 compression predictor.
// Depends on md5_pkg, md5_in_if, md5_out_if and md5_block_compression_top from the RTL.
module md5_block_compression_top_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import md5_pkg::*;

  // Four chaining words, index 0 = a.
  typedef logic [0:3][31:0] quad_t;

  // One expected digest transfer.
  typedef struct packed {
    logic [31:0] digest_word;
    logic [1:0]  word_index;
    logic        last;
  } digest_beat_t;

  // Directed row: one message word; known marks rows whose digest is typed in.
  typedef struct packed {
    logic [31:0] word;
    logic        new_msg;
    logic        known;
    quad_t       digest;
  } stim_row_t;

  // Covers the time from the word-15 transfer to the first result, with a bit of margin on top.
  localparam int DRAIN_CYCLES = 70;

  localparam quad_t MD5_IV = '{32'h67452301, 32'hefcdab89, 32'h98badcfe, 32'h10325476};

  localparam logic [1:0] INIT_REGS [4] = '{REG_INIT_A, REG_INIT_B, REG_INIT_C, REG_INIT_D};

  localparam int ROT_SHIFT [16] = '{7, 12, 17, 22, 5, 9, 14, 20, 4, 11, 16, 23,
                                    6, 10, 15, 21};

  localparam logic [31:0] SINE_K [64] = '{
    32'hd76aa478, 32'he8c7b756, 32'h242070db, 32'hc1bdceee,
    32'hf57c0faf, 32'h4787c62a, 32'ha8304613, 32'hfd469501,
    32'h698098d8, 32'h8b44f7af, 32'hffff5bb1, 32'h895cd7be,
    32'h6b901122, 32'hfd987193, 32'ha679438e, 32'h49b40821,
    32'hf61e2562, 32'hc040b340, 32'h265e5a51, 32'he9b6c7aa,
    32'hd62f105d, 32'h02441453, 32'hd8a1e681, 32'he7d3fbc8,
    32'h21e1cde6, 32'hc33707d6, 32'hf4d50d87, 32'h455a14ed,
    32'ha9e3e905, 32'hfcefa3f8, 32'h676f02d9, 32'h8d2a4c8a,
    32'hfffa3942, 32'h8771f681, 32'h6d9d6122, 32'hfde5380c,
    32'ha4beea44, 32'h4bdecfa9, 32'hf6bb4b60, 32'hbebfbc70,
    32'h289b7ec6, 32'heaa127fa, 32'hd4ef3085, 32'h04881d05,
    32'hd9d4d039, 32'he6db99e5, 32'h1fa27cf8, 32'hc4ac5665,
    32'hf4292244, 32'h432aff97, 32'hab9423a7, 32'hfc93a039,
    32'h655b59c3, 32'h8f0ccc92, 32'hffeff47d, 32'h85845dd1,
    32'h6fa87e4f, 32'hfe2ce6e0, 32'ha3014314, 32'h4e0811a1,
    32'hf7537e82, 32'hbd3af235, 32'h2ad7d2bb, 32'heb86d391
  };

  // Directed table. The first block is the padded empty message sent right after
  // reset with no flag: it chains from the reset value, so the digest is the
  // well-known MD5 of the empty string. Then a flagged start with extreme words
  // that stays partial; the random part either abandons it with a flag or goes on filling it.
  stim_row_t dir_rows [22] = '{
    '{32'h00000080, 1'b0, 1'b0, '0},
    '{32'h00000000, 1'b0, 1'b0, '0},
    '{32'h00000000, 1'b0, 1'b0, '0},
    '{32'h00000000, 1'b0, 1'b0, '0},
    '{32'h00000000, 1'b0, 1'b0, '0},
    '{32'h00000000, 1'b0, 1'b0, '0},
    '{32'h00000000, 1'b0, 1'b0, '0},
    '{32'h00000000, 1'b0, 1'b0, '0},
    '{32'h00000000, 1'b0, 1'b0, '0},
    '{32'h00000000, 1'b0, 1'b0, '0},
    '{32'h00000000, 1'b0, 1'b0, '0},
    '{32'h00000000, 1'b0, 1'b0, '0},
    '{32'h00000000, 1'b0, 1'b0, '0},
    '{32'h00000000, 1'b0, 1'b0, '0},
    '{32'h00000000, 1'b0, 1'b0, '0},
    '{32'h00000000, 1'b0, 1'b1,
      '{32'hd98c1dd4, 32'h04b2008f, 32'h980980e9, 32'h7e42f8ec}},
    '{32'hffffffff, 1'b1, 1'b0, '0},
    '{32'h00000000, 1'b0, 1'b0, '0},
    '{32'h80000000, 1'b0, 1'b0, '0},
    '{32'h00000001, 1'b0, 1'b0, '0},
    '{32'haaaaaaaa, 1'b0, 1'b0, '0},
    '{32'h55555555, 1'b0, 1'b0, '0}
  };

  logic        clk = 1'b0;
  logic        rst_n;
  logic        psel;
  logic        penable;
  logic        pwrite;
  logic [3:0]  paddr;
  logic [31:0] pwdata;
  logic [31:0] prdata;
  logic        pready;

  md5_in_if  in_ch();
  md5_out_if out_ch();

  md5_block_compression_top dut (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_ch   (in_ch),
    .out_ch  (out_ch),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready)
  );

  always #5ns clk = ~clk;

  // Predictor state: init registers, chaining value, word buffer, fill position.
  quad_t        md5_init;
  quad_t        md5_chain;
  logic [31:0]  blk_words [16];
  logic [3:0]   blk_pos;

  digest_beat_t digest_q [$];
  digest_beat_t got_beat;
  digest_beat_t exp_beat;

  int errors;
  int words_sent;
  bit no_idle;     // when set, neither side inserts gaps

  // Mostly back-to-back, sometimes a short gap, now and then a long one.
  function automatic int pick_gap();
    int r;
    if (no_idle) return 0;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  function automatic logic [31:0] rand_word();
    case ($urandom_range(0, 9))
      0: return 32'h00000000;
      1: return 32'hffffffff;
      default: return $urandom();
    endcase
  endfunction

  function automatic logic [31:0] rotl(input logic [31:0] v, input int s);
    return (v << s) | (v >> (32 - s));
  endfunction

  // 64 MD5 steps over the buffered block, then fold into the chaining value.
  function automatic void compress_block();
    logic [31:0] a, b, c, d, f, t;
    int g;
    a = md5_chain[0];
    b = md5_chain[1];
    c = md5_chain[2];
    d = md5_chain[3];
    for (int i = 0; i < 64; i++) begin
      case (i / 16)
        0: begin
          f = d ^ (b & (c ^ d));
          g = i;
        end
        1: begin
          f = c ^ (d & (b ^ c));
          g = 5 * i + 1;
        end
        2: begin
          f = b ^ c ^ d;
          g = 3 * i + 5;
        end
        default: begin
          f = c ^ (b | ~d);
          g = 7 * i;
        end
      endcase
      t = a + f + blk_words[g % 16] + SINE_K[i];
      t = b + rotl(t, ROT_SHIFT[(i / 16) * 4 + i % 4]);
      a = d;
      d = c;
      c = b;
      b = t;
    end
    md5_chain[0] += a;
    md5_chain[1] += b;
    md5_chain[2] += c;
    md5_chain[3] += d;
  endfunction

  // Takes one accepted word; returns 1 when it completes a block.
  function automatic bit absorb_word(input logic [31:0] w, input logic nm);
    if (nm) begin
      md5_chain = md5_init;
      blk_pos   = '0;
    end
    blk_words[blk_pos] = w;
    if (blk_pos != 4'd15) begin
      blk_pos = blk_pos + 4'd1;
      return 1'b0;
    end
    blk_pos = '0;
    compress_block();
    return 1'b1;
  endfunction

  // One input transfer, with a random gap in front. Valid stays high when no gap
  // follows, so it is never lowered and raised in the same step.
  task automatic send_word(input logic [31:0] w, input logic nm,
                           input logic known = 1'b0, input quad_t known_digest = '0);
    digest_beat_t beat;
    int gap;
    gap = pick_gap();
    if (gap > 0) begin
      in_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_ch.valid        <= 1'b1;
    in_ch.message_word <= w;
    in_ch.new_message  <= nm;
    do @(posedge clk); while (!in_ch.ready);
    words_sent++;
    if (absorb_word(w, nm)) begin
      for (int k = 0; k < 4; k++) begin
        beat.digest_word = known ? known_digest[k] : md5_chain[k];
        beat.word_index  = 2'(k);
        beat.last        = (k == 3);
        digest_q.push_back(beat);
      end
    end
  endtask

  // Setup and access phases, then an idle phase so back-to-back calls never
  // reassign psel within a step.
  task automatic cfg_access(input bit wr, input logic [1:0] idx, input logic [31:0] val,
                            output logic [31:0] rd);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= wr;
    paddr   <= {idx, 2'b00};
    pwdata  <= val;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    rd = prdata;
    if (wr) md5_init[idx] = val;
    psel    <= 1'b0;
    penable <= 1'b0;
    @(posedge clk);
  endtask

  task automatic check_regs();
    logic [31:0] rd;
    for (int k = 0; k < 4; k++) begin
      cfg_access(1'b0, INIT_REGS[k], '0, rd);
      if (rd !== md5_init[k]) begin
        $display("%0t: init register %0d readback: expected %h, actual %h",
                 $time, k, md5_init[k], rd);
        errors++;
      end
    end
  endtask

  // Hold the sender off until every expected digest transfer is in, then give
  // the block its latency so nothing is still in flight.
  task automatic settle();
    in_ch.valid <= 1'b0;
    while (digest_q.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  // Receiver: ready high for one cycle, then a random stall (often none).
  initial begin
    int hold;
    hold = 0;
    out_ch.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (hold > 0) begin
        out_ch.ready <= 1'b0;
        hold--;
      end else begin
        out_ch.ready <= 1'b1;
        hold = pick_gap();
      end
    end
  end

  // Result checker: every digest transfer against the oldest expectation.
  always @(posedge clk) begin
    if (rst_n && out_ch.valid && out_ch.ready) begin
      got_beat.digest_word = out_ch.digest_word;
      got_beat.word_index  = out_ch.word_index;
      got_beat.last        = out_ch.last;
      if (digest_q.size() == 0) begin
        $display("%0t: digest transfer with nothing expected: actual %h idx %0d last %b",
                 $time, got_beat.digest_word, got_beat.word_index, got_beat.last);
        errors++;
      end else begin
        exp_beat = digest_q.pop_front();
        if (got_beat.digest_word !== exp_beat.digest_word) begin
          $display("%0t: digest_word mismatch: expected %h, actual %h",
                   $time, exp_beat.digest_word, got_beat.digest_word);
          errors++;
        end
        if (got_beat.word_index !== exp_beat.word_index) begin
          $display("%0t: word_index mismatch: expected %0d, actual %0d",
                   $time, exp_beat.word_index, got_beat.word_index);
          errors++;
        end
        if (got_beat.last !== exp_beat.last) begin
          $display("%0t: last mismatch: expected %b, actual %b",
                   $time, exp_beat.last, got_beat.last);
          errors++;
        end
      end
    end
  end

  // Main sequence.
  initial begin
    quad_t       vals;
    logic [31:0] rd;
    logic        nm0;
    int          ph;
    int          nblk;
    int          nfrag;
    bit          broken;

    errors      = 0;
    words_sent  = 0;
    no_idle     = 1'b0;
    md5_init    = MD5_IV;
    md5_chain   = MD5_IV;
    blk_pos     = '0;
    foreach (blk_words[i]) blk_words[i] = '0;

    rst_n              <= 1'b0;
    in_ch.valid        <= 1'b0;
    in_ch.message_word <= '0;
    in_ch.new_message  <= 1'b0;
    psel               <= 1'b0;
    penable            <= 1'b0;
    pwrite             <= 1'b0;
    paddr              <= '0;
    pwdata             <= '0;

    repeat (2) @(posedge clk);
    rst_n <= 1'b1;

    // Reset values of the init registers.
    check_regs();

    foreach (dir_rows[r])
      send_word(dir_rows[r].word, dir_rows[r].new_msg, dir_rows[r].known,
                dir_rows[r].digest);

    // Random phases. Each starts idle with a new register setting: all zero,
    // all ones, the standard IV, then random. Phase 1 runs with no idling.
    // A phase's first message may skip the flag and so chain across the write.
    ph = 0;
    while (ph < 4 || words_sent < 110) begin
      settle();
      case (ph)
        0: vals = '0;
        1: vals = '1;
        2: vals = MD5_IV;
        default: foreach (vals[k]) vals[k] = $urandom();
      endcase
      for (int k = 0; k < 4; k++) cfg_access(1'b1, INIT_REGS[k], vals[k], rd);
      check_regs();
      no_idle = (ph == 1);

      // Now and then a fragment that the next flagged word throws away.
      broken = ($urandom_range(0, 3) == 0);
      if (broken) begin
        nfrag = $urandom_range(1, 15);
        for (int i = 0; i < nfrag; i++)
          send_word(rand_word(), (i == 0) ? 1'($urandom_range(0, 1)) : 1'b0);
      end
      nm0  = broken ? 1'b1 : ($urandom_range(0, 3) != 0);
      nblk = ($urandom_range(0, 3) == 0) ? 2 : 1;
      for (int b = 0; b < nblk; b++)
        for (int i = 0; i < 16; i++)
          send_word(rand_word(), (b == 0 && i == 0) ? nm0 : 1'b0);
      ph++;
    end

    settle();
    if (errors == 0) begin
      $display("md5_block_compression_top test passed");
    end else begin
      $display("md5_block_compression_top test failed");
    end
    $finish;
  end

  // Watchdog: far beyond the slowest legal run (every gap and stall at its longest).
  initial begin
    #3_000_000;
    $display("md5_block_compression_top test failed");
    $finish;
  end

endmodule

[filelist.f]
rtl/md5_pkg.sv
rtl/md5_in_if.sv
rtl/md5_out_if.sv
rtl/md5_step.sv
rtl/md5_block_compression_top.sv
rtl/md5_chk.sv
bench/md5_block_compression_top_tb.sv
